### hdl/sswg_pkg.sv
package sswg_pkg;

  localparam int unsigned SINE_DEPTH_DEF = 256;
  localparam int unsigned TIME_W_DEF     = 32;
  localparam int unsigned ONE_Q14        = 16384;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  localparam logic [2:0] REG_START_ANGLE = 3'd0;
  localparam logic [2:0] REG_TRIANGLE    = 3'd1;
  localparam logic [2:0] REG_PERIOD      = 3'd2;
  localparam logic [2:0] REG_ITER        = 3'd3;
  localparam logic [2:0] REG_AMPLITUDE   = 3'd4;
  localparam logic [2:0] REG_ENV_COEFF   = 3'd5;
  localparam logic [2:0] REG_DIRECTION   = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_MOD,
    ST_MOD_W,
    ST_WAVE,
    ST_WAVE_W,
    ST_WAVE2,
    ST_ENV,
    ST_ENV_W,
    ST_ENV2,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

  // Raise a Q30 Taylor term by two powers of x.
  function automatic logic [63:0] next_term(input logic [63:0] m, input logic [63:0] x);
    return (((m * x) >> 30) * x) >> 30;
  endfunction

  // Quarter sine in Q1.15 from a fifteenth-order Taylor series in Q30,
  // rounded and saturated to 32767; the table depth is 2**ld.
  function automatic logic [15:0] quarter_sine(input int unsigned k, input int unsigned ld);
    logic [63:0] x, mag, v;
    logic signed [63:0] sum;
    x   = (64'(k) * PI_Q30) >> (ld + 1);
    mag = x;
    sum = $signed(x);
    mag = next_term(mag, x) / 64'd6;
    sum = sum - $signed(mag);
    mag = next_term(mag, x) / 64'd20;
    sum = sum + $signed(mag);
    mag = next_term(mag, x) / 64'd42;
    sum = sum - $signed(mag);
    mag = next_term(mag, x) / 64'd72;
    sum = sum + $signed(mag);
    mag = next_term(mag, x) / 64'd110;
    sum = sum - $signed(mag);
    mag = next_term(mag, x) / 64'd156;
    sum = sum + $signed(mag);
    mag = next_term(mag, x) / 64'd210;
    sum = sum - $signed(mag);
    if (sum < 0) sum = '0;
    v = (64'(sum) + 64'd16384) >> 15;
    if (v > 64'd32767) v = 64'd32767;
    return v[15:0];
  endfunction

endpackage

### hdl/sswg_div.sv
// Restoring divider, one quotient bit per cycle.
module sswg_div #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  sswg_pkg::div_ctl_t ctl_in,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);
  localparam int unsigned CW = $clog2(NW + 1);
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   r_r, r_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [DW:0]   sh;

  always_comb begin
    cnt_nxt = cnt_r;
    q_nxt   = q_r;
    r_nxt   = r_r;
    d_nxt   = d_r;
    sh      = {r_r[DW-1:0], q_r[NW-1]};
    if (ctl_in.start) begin
      cnt_nxt = CW'(NW);
      q_nxt   = num;
      r_nxt   = '0;
      d_nxt   = den;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (sh >= {1'b0, d_r}) begin
        r_nxt = sh - {1'b0, d_r};
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        r_nxt = sh;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign busy = (cnt_r != '0);
  assign quo  = q_r;
  assign rem  = r_r[DW-1:0];
endmodule

### hdl/servo_swing_waveform_generator.sv
// Servo swing waveform generator.
// Input stream word: command (bit 0, tuser) and now_ms (tdata, 32 bits).
// command 0 starts a swing (ignored while one runs) and returns nothing;
// command 1 samples the current angle and returns one output word with
// angle in tdata[15:0] and still_swinging in tuser.
// Each sample runs through one shared restoring divider that resolves one
// quotient bit per cycle: three divisions of 64 bits plus seven steps,
// after which out_tvalid rises. A start is taken while idle, and a new
// start can follow every cycle while no result waits.
// One item is in work at a time; in_tready is low while a sample is in work
// or its result waits.
// Reset clears the swing state (start time 0, idle) and loads the register
// defaults. When the receiver stalls, the result holds in the output
// register and no new item is taken until it leaves.
// Configuration is an APB port with registers at 4*index; pready is high.
module servo_swing_waveform_generator #(
  parameter int unsigned SINE_TABLE_DEPTH = sswg_pkg::SINE_DEPTH_DEF,
  parameter int unsigned TIME_WIDTH       = sswg_pkg::TIME_W_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // now_ms[31:0]
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // angle[15:0]
  output logic        out_tuser,  // still_swinging
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int unsigned LD = $clog2(SINE_TABLE_DEPTH);

  // Registers
  logic [7:0]  start_angle_r;
  logic        triangle_r, dir_r;
  logic [15:0] period_r, iter_r, coeff_r;
  logic [8:0]  amp_r;
  logic [2:0]  ridx;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_angle_r <= 8'd90;
      triangle_r    <= 1'b0;
      period_r      <= 16'd1000;
      iter_r        <= 16'd256;
      amp_r         <= 9'd60;
      coeff_r       <= 16'd16384;
      dir_r         <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      case (ridx)
        sswg_pkg::REG_START_ANGLE: start_angle_r <= cfg_pwdata[7:0];
        sswg_pkg::REG_TRIANGLE:    triangle_r    <= cfg_pwdata[0];
        sswg_pkg::REG_PERIOD:      period_r      <= cfg_pwdata[15:0];
        sswg_pkg::REG_ITER:        iter_r        <= cfg_pwdata[15:0];
        sswg_pkg::REG_AMPLITUDE:   amp_r         <= cfg_pwdata[8:0];
        sswg_pkg::REG_ENV_COEFF:   coeff_r       <= cfg_pwdata[15:0];
        sswg_pkg::REG_DIRECTION:   dir_r         <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[1:0] == 2'b00) begin
      case (ridx)
        sswg_pkg::REG_START_ANGLE: cfg_prdata = {24'd0, start_angle_r};
        sswg_pkg::REG_TRIANGLE:    cfg_prdata = {31'd0, triangle_r};
        sswg_pkg::REG_PERIOD:      cfg_prdata = {16'd0, period_r};
        sswg_pkg::REG_ITER:        cfg_prdata = {16'd0, iter_r};
        sswg_pkg::REG_AMPLITUDE:   cfg_prdata = {23'd0, amp_r};
        sswg_pkg::REG_ENV_COEFF:   cfg_prdata = {16'd0, coeff_r};
        sswg_pkg::REG_DIRECTION:   cfg_prdata = {31'd0, dir_r};
        default:                   cfg_prdata = '0;
      endcase
    end
  end

  // Sine quarter table as constant logic
  logic [15:0] sine_rom [SINE_TABLE_DEPTH+1];
  always_comb begin
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      sine_rom[k] = sswg_pkg::quarter_sine(k, LD);
    end
  end

  sswg_pkg::state_t state_r, state_nxt;
  logic [TIME_WIDTH-1:0] start_time_r;
  logic                  swinging_r;
  logic [31:0]           e_r;        // elapsed, clamped (< 2^32)
  logic [15:0]           p_r;        // effective period
  logic [31:0]           t_r;        // e mod p
  logic [17:0]           deg_r;      // signed wave value
  logic signed [18:0]    dout_r;
  logic                  ovld_r, ouser_r;
  logic [15:0]           oang_r;

  // Divider
  sswg_pkg::div_ctl_t dctl;
  logic [63:0] dnum, dquo;
  logic [31:0] dden, drem;
  logic        dbusy;

  sswg_div #(.NW(64), .DW(32)) u_div (
    .clk(clk), .rst_n(rst_n), .ctl_in(dctl), .num(dnum), .den(dden),
    .busy(dbusy), .quo(dquo), .rem(drem)
  );

  logic accept_in, cmd_start;
  assign in_tready = (state_r == sswg_pkg::ST_IDLE) && !ovld_r;
  assign accept_in = in_tvalid && in_tready;
  assign cmd_start = !in_tuser;

  logic [TIME_WIDTH-1:0] now_t, ediff;
  logic [31:0] limit;
  assign now_t = in_tdata[TIME_WIDTH-1:0];
  assign ediff = now_t - start_time_r;
  logic [15:0] p_eff;
  assign p_eff = (period_r == 16'd0) ? 16'd1 : period_r;
  assign limit = 32'(p_eff) * 32'(iter_r);

  // Wave stage combinational
  logic [LD+1:0] idx;
  logic [1:0]    quad;
  logic [LD-1:0] kk;
  logic [LD:0]   kidx;
  logic [15:0]   sv;
  logic [24:0]   smag;
  logic [17:0]   wave_sine, wave_tri;
  logic [17:0]   ampx;
  logic [17:0]   rr;
  assign idx  = dquo[LD+1:0];
  assign quad = idx[LD+1:LD];
  assign kk   = idx[LD-1:0];
  assign kidx = quad[0] ? (LD+1)'(SINE_TABLE_DEPTH) - {1'b0, kk} : {1'b0, kk};
  assign sv   = sine_rom[kidx];
  assign smag = 25'(amp_r[8:1]) * 25'(sv);
  assign wave_sine = quad[1] ? -18'(smag[24:15]) : 18'(smag[24:15]);
  assign ampx = 18'(amp_r);
  assign rr   = dquo[17:0];
  always_comb begin
    if (t_r < 32'(p_r[15:2]))
      wave_tri = rr;
    else if (t_r < 32'((18'(p_r) * 18'd3) >> 2))
      wave_tri = ampx - rr;
    else
      wave_tri = rr - (ampx << 1);
  end

  // Envelope
  logic        neg_d, neg_env, cge;
  logic [15:0] cdiff;
  logic [16:0] absd;
  logic [47:0] ecd;
  assign cge    = coeff_r >= 16'(sswg_pkg::ONE_Q14);
  assign cdiff  = cge ? coeff_r - 16'(sswg_pkg::ONE_Q14) : 16'(sswg_pkg::ONE_Q14) - coeff_r;
  assign neg_d  = deg_r[17];
  assign neg_env = cge ? neg_d : !neg_d;
  assign absd   = neg_d ? 17'(-deg_r) : deg_r[16:0];
  assign ecd    = e_r * 48'(cdiff);
  logic [47:0] mag_r;
  logic        force0;
  assign force0 = !cge && (ecd > 48'(p_r) * 48'(sswg_pkg::ONE_Q14));

  logic [63:0] num_env;
  assign num_env = 64'(mag_r) * 64'(absd);

  // Output math
  logic signed [19:0] dfin, dsat;
  always_comb begin
    dfin = dir_r ? 20'(dout_r) : -20'(dout_r);
    dfin = dfin + 20'(start_angle_r);
    dsat = dfin;
    if (dfin > 20'sd32767) dsat = 20'sd32767;
    if (dfin < -20'sd32768) dsat = -20'sd32768;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sswg_pkg::ST_IDLE:   if (accept_in && !cmd_start) state_nxt = sswg_pkg::ST_CLAMP;
      sswg_pkg::ST_CLAMP:  state_nxt = sswg_pkg::ST_MOD;
      sswg_pkg::ST_MOD:    state_nxt = sswg_pkg::ST_MOD_W;
      sswg_pkg::ST_MOD_W:  if (!dbusy) state_nxt = sswg_pkg::ST_WAVE;
      sswg_pkg::ST_WAVE:   state_nxt = sswg_pkg::ST_WAVE_W;
      sswg_pkg::ST_WAVE_W: if (!dbusy) state_nxt = sswg_pkg::ST_WAVE2;
      sswg_pkg::ST_WAVE2:  state_nxt = sswg_pkg::ST_ENV;
      sswg_pkg::ST_ENV:    state_nxt = sswg_pkg::ST_ENV_W;
      sswg_pkg::ST_ENV_W:  if (!dbusy) state_nxt = sswg_pkg::ST_ENV2;
      sswg_pkg::ST_ENV2:   state_nxt = sswg_pkg::ST_OUT;
      sswg_pkg::ST_OUT:    state_nxt = sswg_pkg::ST_IDLE;
      default:             state_nxt = sswg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    dctl = '0;
    dnum = '0;
    dden = '0;
    case (state_r)
      sswg_pkg::ST_MOD: begin
        dctl.start = 1'b1;
        dnum = 64'(e_r);
        dden = 32'(p_r);
      end
      sswg_pkg::ST_WAVE: begin
        dctl.start = 1'b1;
        dden = 32'(p_r);
        if (triangle_r) dnum = 64'(t_r) * 64'({amp_r, 1'b0});
        else dnum = 64'(t_r) << (LD + 2);
      end
      sswg_pkg::ST_ENV: begin
        dctl.start = 1'b1;
        dnum = num_env;
        dden = 32'(p_r) << 14;
      end
      default: ;
    endcase
    dctl.busy = dbusy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sswg_pkg::ST_IDLE;
      start_time_r <= '0;
      swinging_r   <= 1'b0;
      ovld_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ovld_r && out_tready) ovld_r <= 1'b0;
      if (accept_in) begin
        if (cmd_start) begin
          if (!swinging_r) begin
            start_time_r <= now_t;
            swinging_r   <= 1'b1;
          end
        end else begin
          p_r <= p_eff;
          if ((56'(ediff) << 8) > 56'(limit)) begin
            swinging_r <= 1'b0;
            e_r        <= 32'(limit >> 8);
          end else begin
            e_r <= 32'(ediff);
          end
        end
      end
      if (state_r == sswg_pkg::ST_WAVE) t_r <= drem;
      if (state_r == sswg_pkg::ST_MOD_W && !dbusy) t_r <= drem;
      if (state_r == sswg_pkg::ST_WAVE2) deg_r <= triangle_r ? wave_tri : wave_sine;
      // hold e * |C - 1| ready for the envelope division
      if (state_r == sswg_pkg::ST_WAVE2) mag_r <= ecd;
      if (state_r == sswg_pkg::ST_ENV2) begin
        if (force0) dout_r <= '0;
        else dout_r <= 19'($signed(deg_r)) +
                       (neg_env ? -19'(dquo[18:0]) : 19'(dquo[18:0]));
      end
      if (state_r == sswg_pkg::ST_OUT) begin
        ovld_r  <= 1'b1;
        oang_r  <= 16'(dsat);
        ouser_r <= swinging_r;
      end
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = oang_r;
  assign out_tuser  = ouser_r;
endmodule
